// ===== src/subseed_window_extractor_core_macros.svh =====
// Assertion macros shared by the files that check this block.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SUBSEED_WINDOW_EXTRACTOR_CORE_MACROS_SVH
`define SUBSEED_WINDOW_EXTRACTOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("subseed window extractor: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("subseed window extractor: next-cycle check failed");

`endif

// ===== src/swe_pkg.sv =====
package swe_pkg;

    // Field widths fixed by the interface.
    localparam int LETTER_W    = 5;
    localparam int LETTER_IN_W = 8;
    localparam int POS_W       = 2;
    localparam int CFG_W       = 6;
    localparam int SEED_SLOTS  = 4;
    localparam int SEED_W      = SEED_SLOTS * LETTER_W;
    localparam int OFFSET_W    = 32;

    // Defaults for the top-level parameters.
    localparam int SPAN_DEFAULT           = 4;
    localparam int ALPHABET_LIMIT_DEFAULT = 32;

    // Reset value of the alphabet size register.
    localparam logic [CFG_W-1:0] ALPHABET_RESET = 6'd32;

    // Request kinds.
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_LETTER = 1'b1;

    // Access request to one equivalence table bank.
    typedef struct packed {
        logic                we;
        logic [LETTER_W-1:0] waddr;
        logic [LETTER_W-1:0] wdata;
        logic                re;
        logic [LETTER_W-1:0] raddr;
    } ram_req_t;

endpackage

// ===== src/swe_ram.sv =====
module swe_ram #(
    parameter int DEPTH = swe_pkg::ALPHABET_LIMIT_DEFAULT
) (
    input  logic                            clk,
    input  swe_pkg::ram_req_t               req,
    output logic [swe_pkg::LETTER_W-1:0]    rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [swe_pkg::LETTER_W-1:0] mem [DEPTH];
    logic [swe_pkg::LETTER_W-1:0] rdata_reg;

    // One write port and one registered read port; the read data holds when no read is issued.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/subseed_window_extractor_core.sv =====
// Spaced subset seed extractor.
// The input channel (in_valid/in_ready) carries one request per accepted cycle. A request
// with kind set to the load code writes one equivalence table entry (table_position,
// table_letter, table_value) and never yields a result. A request with kind set to the
// letter code shifts letter into a window of SPAN letters; a letter at or above the
// configured alphabet size is bad and restarts the run of valid letters.
// Once SPAN valid letters stand in a row, the output channel (out_valid/out_ready) carries
// seed_word, the window letters translated through their per-position table banks, and
// window_offset, the index of the window's first letter. seq_last ends a sequence.
// Throughput is one request per cycle while the receiver keeps up: the table has one bank,
// with its own write and read port, per window position, so every window letter is looked
// up in the same cycle. From acceptance to out_valid a result passes the bank reads, then
// the output register. When the receiver stalls, the output register holds its result, a
// second result waits at the bank outputs, and in_ready falls only when both are full.
// Reset clears the window, the run count, the letter index and the pipeline, and sets the
// alphabet size to 32. The table itself is not cleared; entries must be loaded before use.
// cfg_we writes cfg_data into the alphabet size register; it should be used only while idle.
`include "subseed_window_extractor_core_macros.svh"

module subseed_window_extractor_core #(
    parameter int SPAN           = swe_pkg::SPAN_DEFAULT,
    parameter int ALPHABET_LIMIT = swe_pkg::ALPHABET_LIMIT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [swe_pkg::CFG_W-1:0]         cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [swe_pkg::POS_W-1:0]         table_position,
    input  logic [swe_pkg::LETTER_W-1:0]      table_letter,
    input  logic [swe_pkg::LETTER_W-1:0]      table_value,
    input  logic [swe_pkg::LETTER_IN_W-1:0]   letter,
    input  logic                              seq_last,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [swe_pkg::SEED_W-1:0]        seed_word,
    output logic [swe_pkg::OFFSET_W-1:0]      window_offset
);

    localparam int LW    = swe_pkg::LETTER_W;
    localparam int RUN_W = $clog2(SPAN + 1);
    // Only window positions that the seed word can hold need a table bank.
    localparam int NB    = (SPAN < swe_pkg::SEED_SLOTS) ? SPAN : swe_pkg::SEED_SLOTS;

    // Configuration.
    logic [swe_pkg::CFG_W-1:0] alphabet_reg;
    logic [swe_pkg::CFG_W-1:0] eff_alphabet;

    // Window state.
    logic [LW-1:0]                 window_reg   [SPAN];
    logic [LW-1:0]                 window_next  [SPAN];
    logic [LW-1:0]                 window_shift [SPAN];
    logic [RUN_W-1:0]              valid_run_reg;
    logic [RUN_W-1:0]              valid_run_next;
    logic [RUN_W-1:0]              run_inc;
    logic [swe_pkg::OFFSET_W-1:0]  letter_index_reg;
    logic [swe_pkg::OFFSET_W-1:0]  letter_index_next;

    // Pipeline.
    logic                          in_accept;
    logic                          letter_accept;
    logic                          good_letter;
    logic                          emit;
    logic                          s2_load;
    logic                          s1_valid_reg;
    logic [swe_pkg::OFFSET_W-1:0]  s1_offset_reg;
    logic                          out_valid_reg;
    logic [swe_pkg::SEED_W-1:0]    seed_word_reg;
    logic [swe_pkg::OFFSET_W-1:0]  window_offset_reg;
    logic [swe_pkg::SEED_W-1:0]    seed_comb;

    // Table banks.
    swe_pkg::ram_req_t             bank_req   [NB];
    logic [LW-1:0]                 bank_rdata [NB];
    logic                          table_write_ok;

    // A new request may enter unless the bank outputs and a stalled output register are full.
    assign s2_load       = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready      = !s1_valid_reg || s2_load;
    assign in_accept     = in_valid && in_ready;
    assign letter_accept = in_accept && (kind == swe_pkg::KIND_LETTER);

    // Alphabet sizes above the limit behave as the limit itself.
    assign eff_alphabet = (alphabet_reg > swe_pkg::CFG_W'(ALPHABET_LIMIT))
                        ? swe_pkg::CFG_W'(ALPHABET_LIMIT) : alphabet_reg;
    assign good_letter  = letter < {2'b00, eff_alphabet};

    assign run_inc = (valid_run_reg < RUN_W'(SPAN)) ? (valid_run_reg + 1'b1) : valid_run_reg;
    assign emit    = letter_accept && good_letter && (run_inc == RUN_W'(SPAN));

    // The window as it stands after a good letter has been shifted in.
    always_comb
    begin
        for (int i = 0; i < SPAN - 1; i++)
        begin
            window_shift[i] = window_reg[i + 1];
        end
        window_shift[SPAN - 1] = letter[LW-1:0];
    end

    // Window, run and index updates; the end of a sequence clears them after the letter.
    always_comb
    begin
        window_next       = window_reg;
        valid_run_next    = valid_run_reg;
        letter_index_next = letter_index_reg;
        if (letter_accept)
        begin
            if (good_letter)
            begin
                window_next    = window_shift;
                valid_run_next = run_inc;
            end
            else
            begin
                valid_run_next = '0;
            end
            letter_index_next = letter_index_reg + 1'b1;
            if (seq_last)
            begin
                for (int i = 0; i < SPAN; i++)
                begin
                    window_next[i] = '0;
                end
                valid_run_next    = '0;
                letter_index_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_reg     <= swe_pkg::ALPHABET_RESET;
            valid_run_reg    <= '0;
            letter_index_reg <= '0;
            for (int i = 0; i < SPAN; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                alphabet_reg <= cfg_data;
            end
            valid_run_reg    <= valid_run_next;
            letter_index_reg <= letter_index_next;
            window_reg       <= window_next;
        end
    end

    // A table write lands only for letters inside the table; positions beyond the banks
    // never match a bank and are dropped.
    assign table_write_ok = in_accept && (kind == swe_pkg::KIND_LOAD)
                         && ({1'b0, table_letter} < swe_pkg::CFG_W'(ALPHABET_LIMIT));

    // Each bank reads the translated letter for its own window position. Because every
    // position is read again for each seed, a table write is seen by the very next letter.
    for (genvar g = 0; g < NB; g++)
    begin : g_bank
        always_comb
        begin
            bank_req[g].we    = table_write_ok && (int'(table_position) == g);
            bank_req[g].waddr = table_letter;
            bank_req[g].wdata = table_value;
            bank_req[g].re    = emit;
            bank_req[g].raddr = window_shift[g];
        end

        swe_ram #(
            .DEPTH (ALPHABET_LIMIT)
        ) u_bank (
            .clk   (clk),
            .req   (bank_req[g]),
            .rdata (bank_rdata[g])
        );
    end

    // Pack the bank outputs, position 0 in the lowest bits.
    always_comb
    begin
        seed_comb = '0;
        for (int i = 0; i < NB; i++)
        begin
            seed_comb[i*LW +: LW] = bank_rdata[i];
        end
    end

    // Stage one waits for the bank reads; stage two is the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_load)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s2_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_offset_reg <= letter_index_reg - swe_pkg::OFFSET_W'(SPAN - 1);
        end
        if (s2_load)
        begin
            seed_word_reg     <= seed_comb;
            window_offset_reg <= s1_offset_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign seed_word     = seed_word_reg;
    assign window_offset = window_offset_reg;

    // The run count never passes the window length.
    `SWE_ASSERT_SAME(a_run_bounded, 1'b1, valid_run_reg <= RUN_W'(SPAN))
    // With both pipeline stages full and the receiver stalled, no request may enter.
    `SWE_ASSERT_SAME(a_full_blocks, s1_valid_reg && out_valid_reg && !out_ready, !in_ready)
    // A completed window always reaches the read stage in the next cycle.
    `SWE_ASSERT_NEXT(a_emit_lands, emit, s1_valid_reg)
    // A table load into an empty pipeline never produces a result.
    `SWE_ASSERT_NEXT(a_load_silent,
        in_accept && (kind == swe_pkg::KIND_LOAD) && !s1_valid_reg, !s1_valid_reg)

endmodule

// ===== tb/tb_subseed_window_extractor_core.sv =====
module tb_subseed_window_extractor_core;

    // The block is built with its default span and alphabet limit, and the
    // predictor below is sized to match.
    localparam int SPAN        = swe_pkg::SPAN_DEFAULT;
    localparam int ALPHA_LIMIT = swe_pkg::ALPHABET_LIMIT_DEFAULT;

    // A request passes the bank reads and the output register, so these idle
    // cycles are ample for a request that yields no seed to leave the pipeline.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int MAX_IDLE      = 17;
    localparam int WATCHDOG_TIME = 1000000;

    // One seed that the block ought to produce, in order of acceptance.
    typedef struct packed {
        logic [swe_pkg::SEED_W-1:0]   seed;
        logic [swe_pkg::OFFSET_W-1:0] offset;
    } seed_expect_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [swe_pkg::CFG_W-1:0]       cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic                            kind;
    logic [swe_pkg::POS_W-1:0]       table_position;
    logic [swe_pkg::LETTER_W-1:0]    table_letter;
    logic [swe_pkg::LETTER_W-1:0]    table_value;
    logic [swe_pkg::LETTER_IN_W-1:0] letter;
    logic                            seq_last;
    logic                            out_valid;
    logic                            out_ready;
    logic [swe_pkg::SEED_W-1:0]      seed_word;
    logic [swe_pkg::OFFSET_W-1:0]    window_offset;

    // Private copy of the block's state, advanced once per accepted request.
    logic [swe_pkg::CFG_W-1:0]    model_alphabet = swe_pkg::ALPHABET_RESET;
    logic [swe_pkg::LETTER_W-1:0] model_window [SPAN];
    int                           model_run      = 0;
    logic [swe_pkg::OFFSET_W-1:0] model_seq_pos  = '0;
    logic [swe_pkg::LETTER_W-1:0] model_equiv [SPAN][ALPHA_LIMIT];

    // Seeds predicted but not yet seen at the output, oldest first.
    seed_expect_t pending_seeds [$];

    // Idling controls. The sender and the receiver each draw a wait per item
    // while their idle switch is on; a long receiver hold-off can be requested
    // by a test and is counted down in the receiver process itself.
    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;
    int rx_stall_left = 0;
    int rx_hold_cycles = 0;

    int error_count     = 0;
    int loads_sent      = 0;
    int letters_sent    = 0;
    int seeds_checked   = 0;
    int settings_used   = 0;
    int in_stall_cycles = 0;

    subseed_window_extractor_core #(
        .SPAN           (SPAN),
        .ALPHABET_LIMIT (ALPHA_LIMIT)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .table_position (table_position),
        .table_letter   (table_letter),
        .table_value    (table_value),
        .letter         (letter),
        .seq_last       (seq_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .seed_word      (seed_word),
        .window_offset  (window_offset)
    );

    always #1 clk = ~clk;

    // The run is abandoned if it has not finished long after the slowest
    // correct run would have done.
    initial
    begin
        #(WATCHDOG_TIME);
        $display("DONE: errors detected");
        $finish;
    end

    // Letters at or above the configured size are bad; sizes beyond the
    // table's limit behave as the limit.
    function automatic int effective_alphabet();
        return (int'(model_alphabet) > ALPHA_LIMIT) ? ALPHA_LIMIT : int'(model_alphabet);
    endfunction

    // Advances the private state by one accepted request and queues the seed
    // it produces, if any. A load writes one table entry and nothing else; its
    // letter and sequence-end fields are ignored.
    task automatic predict_seed(input logic req_kind, input logic [swe_pkg::POS_W-1:0] pos,
                                input logic [swe_pkg::LETTER_W-1:0] t_letter,
                                input logic [swe_pkg::LETTER_W-1:0] t_value,
                                input logic [swe_pkg::LETTER_IN_W-1:0] l, input logic last);
        seed_expect_t result;
        if (req_kind == swe_pkg::KIND_LOAD)
        begin
            if (int'(pos) < SPAN && int'(t_letter) < ALPHA_LIMIT)
                model_equiv[pos][t_letter] = t_value;
            return;
        end
        if (int'(l) >= effective_alphabet())
        begin
            // A bad letter breaks the run but still takes up a sequence index.
            model_run = 0;
        end
        else
        begin
            for (int i = 0; i < SPAN - 1; i++)
                model_window[i] = model_window[i + 1];
            model_window[SPAN - 1] = l[swe_pkg::LETTER_W-1:0];
            if (model_run < SPAN)
                model_run++;
            if (model_run >= SPAN)
            begin
                result.seed = '0;
                for (int i = 0; i < SPAN; i++)
                    result.seed[swe_pkg::LETTER_W*i +: swe_pkg::LETTER_W] =
                        model_equiv[i][model_window[i]];
                result.offset = model_seq_pos - swe_pkg::OFFSET_W'(SPAN - 1);
                pending_seeds.insert(pending_seeds.size(), result);
            end
        end
        model_seq_pos = model_seq_pos + 1'b1;
        if (last)
        begin
            for (int i = 0; i < SPAN; i++)
                model_window[i] = '0;
            model_run     = 0;
            model_seq_pos = '0;
        end
    endtask

    // Offers one request after the sender's drawn wait and holds it until it
    // is accepted. A request that follows with no wait is driven on the next
    // falling edge without valid ever dropping.
    task automatic send_request(input logic req_kind, input logic [swe_pkg::POS_W-1:0] pos,
                                input logic [swe_pkg::LETTER_W-1:0] t_letter,
                                input logic [swe_pkg::LETTER_W-1:0] t_value,
                                input logic [swe_pkg::LETTER_IN_W-1:0] l, input logic last);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        kind           <= req_kind;
        table_position <= pos;
        table_letter   <= t_letter;
        table_value    <= t_value;
        letter         <= l;
        seq_last       <= last;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            in_stall_cycles++;
            @(posedge clk);
        end
        predict_seed(req_kind, pos, t_letter, t_value, l, last);
        if (req_kind == swe_pkg::KIND_LOAD)
            loads_sent++;
        else
            letters_sent++;
    endtask

    // The ignored fields of each request kind carry random values, so that the
    // block is seen to disregard them.
    task automatic send_load(input logic [swe_pkg::POS_W-1:0] pos,
                             input logic [swe_pkg::LETTER_W-1:0] t_letter,
                             input logic [swe_pkg::LETTER_W-1:0] t_value);
        send_request(swe_pkg::KIND_LOAD, pos, t_letter, t_value,
                     swe_pkg::LETTER_IN_W'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
    endtask

    task automatic send_letter(input logic [swe_pkg::LETTER_IN_W-1:0] l, input logic last);
        send_request(swe_pkg::KIND_LETTER, swe_pkg::POS_W'($urandom_range(0, 3)),
                     swe_pkg::LETTER_W'($urandom_range(0, 31)),
                     swe_pkg::LETTER_W'($urandom_range(0, 31)),
                     l, last);
    endtask

    // Mostly good letters, so that runs grow long enough to give seeds, with
    // bad letters across the whole of the remaining code range.
    function automatic logic [swe_pkg::LETTER_IN_W-1:0] draw_letter();
        int eff;
        eff = effective_alphabet();
        if (eff > 0 && $urandom_range(0, 99) < 88)
            return swe_pkg::LETTER_IN_W'($urandom_range(0, eff - 1));
        return swe_pkg::LETTER_IN_W'($urandom_range(eff, 255));
    endfunction

    // Drops valid and waits until every predicted seed has been taken, then a
    // few more cycles so that requests that gave no seed have left the block.
    task automatic wait_idle();
        int n;
        @(negedge clk);
        in_valid <= 1'b0;
        n = 0;
        while (pending_seeds.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the alphabet size register; only ever called while the block is idle.
    task automatic write_alphabet(input logic [swe_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        model_alphabet = value;
        settings_used++;
    endtask

    // Receiver: after each accepted seed it draws a stall, and a requested
    // hold-off keeps ready low for that many cycles regardless.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (rx_stall_left > 0)
            begin
                out_ready <= 1'b0;
                rx_stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Every accepted seed is compared with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        seed_expect_t oldest;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_seeds.size() == 0)
            begin
                $display("%0t: unexpected seed: expected none, actual seed %h offset %0d",
                         $time, seed_word, window_offset);
                error_count++;
            end
            else
            begin
                oldest = pending_seeds.pop_front();
                if (seed_word !== oldest.seed)
                begin
                    $display("%0t: seed_word mismatch: expected %h, actual %h",
                             $time, oldest.seed, seed_word);
                    error_count++;
                end
                if (window_offset !== oldest.offset)
                begin
                    $display("%0t: window_offset mismatch: expected %0d, actual %0d",
                             $time, oldest.offset, window_offset);
                    error_count++;
                end
            end
            seeds_checked++;
            rx_stall_left = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        end
    end

    // Every table entry is written before any letter is sent, so no seed can
    // ever look up an entry that holds nothing defined.
    task automatic test_table_load();
        for (int p = 0; p < SPAN; p++)
            for (int t = 0; t < ALPHA_LIMIT; t++)
                send_load(swe_pkg::POS_W'(p), swe_pkg::LETTER_W'(t),
                          swe_pkg::LETTER_W'($urandom_range(0, 31)));
        wait_idle();
    endtask

    // Hand-picked letters at the default alphabet size: the extreme good
    // letters, a table rewrite in mid-sequence, bad letters at both ends of
    // the bad range, and sequence ends on good and on bad letters.
    task automatic test_directed_letters();
        send_letter(8'd0, 1'b0);
        send_letter(8'd31, 1'b0);
        send_letter(8'd0, 1'b0);
        send_letter(8'd31, 1'b0);
        send_letter(8'd17, 1'b0);
        // The load carries a sequence end and a bad letter, both of which must be ignored.
        send_request(swe_pkg::KIND_LOAD, swe_pkg::POS_W'(SPAN - 1), 5'd5, 5'd31, 8'd255, 1'b1);
        send_letter(8'd5, 1'b0);
        send_letter(8'd32, 1'b0);
        send_letter(8'd255, 1'b0);
        send_letter(8'd1, 1'b0);
        send_letter(8'd2, 1'b0);
        send_letter(8'd3, 1'b0);
        send_letter(8'd4, 1'b0);
        send_letter(8'd9, 1'b1);
        send_letter(8'd6, 1'b0);
        send_letter(8'd7, 1'b0);
        send_letter(8'd8, 1'b0);
        send_letter(8'd9, 1'b0);
        send_letter(8'd200, 1'b1);
        send_letter(8'd1, 1'b0);
        send_letter(8'd2, 1'b0);
        send_letter(8'd3, 1'b0);
        send_letter(8'd4, 1'b1);
        wait_idle();
    endtask

    // The smallest alphabet, an alphabet with no good letter at all, and the
    // largest register value, which must behave as the table's limit.
    task automatic test_alphabet_extremes();
        write_alphabet(6'd1);
        repeat (4) send_letter(8'd0, 1'b0);
        send_letter(8'd1, 1'b0);
        send_letter(8'd0, 1'b1);
        wait_idle();
        write_alphabet(6'd0);
        repeat (5) send_letter(8'd0, 1'b0);
        send_letter(8'd0, 1'b1);
        wait_idle();
        write_alphabet(6'd63);
        repeat (4) send_letter(8'd31, 1'b0);
        send_letter(8'd32, 1'b0);
        send_letter(8'd63, 1'b0);
        for (int i = 0; i < 4; i++)
            send_letter(swe_pkg::LETTER_IN_W'(i), (i == 3));
        wait_idle();
        write_alphabet(swe_pkg::ALPHABET_RESET);
    endtask

    // The receiver holds off for a long stretch while the sender streams good
    // letters with no gaps, so the pipeline fills and in_ready must fall. The
    // sender then pauses until every seed has been taken.
    task automatic test_backpressure();
        tx_idle_on     = 1'b0;
        rx_hold_cycles = 80;
        for (int i = 0; i < 24; i++)
            send_letter(swe_pkg::LETTER_IN_W'($urandom_range(0, 31)), 1'b0);
        wait_idle();
        tx_idle_on = 1'b1;
    endtask

    // Random traffic in phases with different alphabet sizes. Idling on each
    // side is switched on and off in blocks, so that some stretches stream at
    // full rate and others leave gaps on every phase of the pipeline.
    task automatic test_random_traffic();
        logic [swe_pkg::CFG_W-1:0] phase_alpha;
        int phase_items;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: phase_alpha = 6'd32;
                1: phase_alpha = 6'd1;
                2: phase_alpha = 6'd63;
                3: phase_alpha = 6'd2;
                4: phase_alpha = swe_pkg::CFG_W'($urandom_range(3, 31));
                5: phase_alpha = 6'd0;
                6: phase_alpha = swe_pkg::CFG_W'($urandom_range(33, 62));
                default: phase_alpha = swe_pkg::CFG_W'($urandom_range(0, 63));
            endcase
            // With no good letter there is little to learn, so that phase is short.
            phase_items = (phase == 5) ? 60 : 230;
            wait_idle();
            write_alphabet(phase_alpha);
            for (int n = 0; n < phase_items; n++)
            begin
                if (n % 40 == 0)
                begin
                    tx_idle_on = 1'($urandom_range(0, 1));
                    rx_idle_on = 1'($urandom_range(0, 1));
                end
                if ($urandom_range(0, 99) < 10)
                    send_load(swe_pkg::POS_W'($urandom_range(0, 3)),
                              swe_pkg::LETTER_W'($urandom_range(0, 31)),
                              swe_pkg::LETTER_W'($urandom_range(0, 31)));
                else
                    send_letter(draw_letter(), ($urandom_range(0, 31) == 0));
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        // All inputs are known from the first instant; reset is held low, then
        // released on a falling edge.
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        kind           = swe_pkg::KIND_LOAD;
        table_position = '0;
        table_letter   = '0;
        table_value    = '0;
        letter         = '0;
        seq_last       = 1'b0;
        for (int i = 0; i < SPAN; i++)
            model_window[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The reset value of the register is checked before it is first written.
        test_table_load();
        test_directed_letters();
        test_alphabet_extremes();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        if (pending_seeds.size() != 0)
        begin
            $display("%0t: %0d seeds never arrived: expected seed %h offset %0d, actual none",
                     $time, pending_seeds.size(), pending_seeds[0].seed,
                     pending_seeds[0].offset);
            error_count += pending_seeds.size();
        end

        $display("Run covered %0d requests (%0d table loads, %0d letters)",
                 loads_sent + letters_sent, loads_sent, letters_sent);
        $display("over %0d alphabet settings; %0d seeds compared, input held off %0d cycles.",
                 settings_used + 1, seeds_checked, in_stall_cycles);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/swe_pkg.sv
src/swe_ram.sv
src/subseed_window_extractor_core.sv
tb/tb_subseed_window_extractor_core.sv
